// ===== rtl/core/sm83alu_pkg.sv =====
// sm83alu_pkg: operation codes, flag layout and beat payload types of the sm83 alu
// no dependencies; used by the channel interfaces, the datapath and the top level
`default_nettype none

package sm83alu_pkg;

    // operation codes carried in the command field
    typedef enum logic [4:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_CP    = 5'd4,
        CMD_AND   = 5'd5,
        CMD_OR    = 5'd6,
        CMD_XOR   = 5'd7,
        CMD_INC   = 5'd8,
        CMD_DEC   = 5'd9,
        CMD_RLC   = 5'd10,
        CMD_RRC   = 5'd11,
        CMD_RL    = 5'd12,
        CMD_RR    = 5'd13,
        CMD_SLA   = 5'd14,
        CMD_SRA   = 5'd15,
        CMD_SWAP  = 5'd16,
        CMD_SRL   = 5'd17,
        CMD_BIT   = 5'd18,
        CMD_RES   = 5'd19,
        CMD_SET   = 5'd20,
        CMD_DAA   = 5'd21,
        CMD_CPL   = 5'd22,
        CMD_CCF   = 5'd23,
        CMD_SCF   = 5'd24,
        CMD_RLCA  = 5'd25,
        CMD_RRCA  = 5'd26,
        CMD_RLA   = 5'd27,
        CMD_RRA   = 5'd28,
        CMD_ADD16 = 5'd29,
        CMD_ADDSP = 5'd30
    } t_cmd;

    // decimal adjust corrections and limit
    localparam logic [7:0] DAA_LO_FIX = 8'h06;
    localparam logic [7:0] DAA_HI_FIX = 8'h60;
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    // flags packed z n h c, bit 3 down to 0
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // input beat
    typedef struct packed {
        logic [4:0]  command;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        t_flags      flags_in;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_alu_req;

    // result beat
    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] word_result;
        t_flags      flags_out;
        logic        write_back;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/sm83alu_if.sv =====
// sm83alu_req_if / sm83alu_rsp_if: valid/ready channels for request and result beats
// depends on sm83alu_pkg for the payload types
`default_nettype none

interface sm83alu_req_if;
    import sm83alu_pkg::*;

    logic     valid;
    logic     ready;
    t_alu_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sm83alu_rsp_if;
    import sm83alu_pkg::*;

    logic     valid;
    logic     ready;
    t_alu_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sm83alu_calc.sv =====
// sm83alu_calc: combinational datapath, one request beat in, one result beat out
// depends on sm83alu_pkg
`default_nettype none

module sm83alu_calc (
    input  sm83alu_pkg::t_alu_req i_req,
    output sm83alu_pkg::t_alu_rsp o_rsp
);
    import sm83alu_pkg::*;

    t_cmd        cmd;
    logic [7:0]  a;
    logic [7:0]  b;
    t_flags      fi;
    logic        use_c;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  rot_r;
    logic        rot_c;
    logic [7:0]  bit_mask;
    logic [7:0]  daa_r;
    logic        daa_c;
    logic [16:0] w17;
    logic [12:0] h13;
    logic [15:0] sp_sum;
    logic [4:0]  sp_h5;
    logic [8:0]  sp_c9;
    logic [7:0]  r;
    logic [15:0] w;
    t_flags      f;
    logic        wr;

    assign cmd      = t_cmd'(i_req.command);
    assign a        = i_req.acc;
    assign b        = i_req.operand;
    assign fi       = i_req.flags_in;
    assign bit_mask = 8'b1 << i_req.bit_index;

    // shared adder and subtractor, carry in only for adc and sbc
    assign use_c = ((cmd == CMD_ADC) || (cmd == CMD_SBC)) ? fi.c : 1'b0;
    assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, use_c};
    assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c};
    assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, use_c};
    assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c};

    // 16-bit adds
    assign w17    = {1'b0, i_req.word_a} + {1'b0, i_req.word_b};
    assign h13    = {1'b0, i_req.word_a[11:0]} + {1'b0, i_req.word_b[11:0]};
    assign sp_sum = i_req.word_a + {{8{b[7]}}, b};
    assign sp_h5  = {1'b0, i_req.word_a[3:0]} + {1'b0, b[3:0]};
    assign sp_c9  = {1'b0, i_req.word_a[7:0]} + {1'b0, b};

    // rotate, shift and swap unit
    always_comb begin
        case (cmd)
            CMD_RLC, CMD_RLCA: begin
                rot_r = {a[6:0], a[7]};
                rot_c = a[7];
            end
            CMD_RRC, CMD_RRCA: begin
                rot_r = {a[0], a[7:1]};
                rot_c = a[0];
            end
            CMD_RL, CMD_RLA: begin
                rot_r = {a[6:0], fi.c};
                rot_c = a[7];
            end
            CMD_RR, CMD_RRA: begin
                rot_r = {fi.c, a[7:1]};
                rot_c = a[0];
            end
            CMD_SLA: begin
                rot_r = {a[6:0], 1'b0};
                rot_c = a[7];
            end
            CMD_SRA: begin
                rot_r = {a[7], a[7:1]};
                rot_c = a[0];
            end
            CMD_SWAP: begin
                rot_r = {a[3:0], a[7:4]};
                rot_c = 1'b0;
            end
            default: begin
                rot_r = {1'b0, a[7:1]};
                rot_c = a[0];
            end
        endcase
    end

    // decimal adjust after add or subtract
    always_comb begin
        daa_r = a;
        daa_c = fi.c;
        if (!fi.n) begin
            if (fi.c || (a > DAA_LIMIT)) begin
                daa_r = daa_r + DAA_HI_FIX;
                daa_c = 1'b1;
            end
            if (fi.h || (a[3:0] > DIGIT_MAX)) begin
                daa_r = daa_r + DAA_LO_FIX;
            end
        end else begin
            if (fi.h) begin
                daa_r = daa_r - DAA_LO_FIX;
            end
            if (fi.c) begin
                daa_r = daa_r - DAA_HI_FIX;
            end
        end
    end

    // operation select and flag rules
    always_comb begin
        r  = a;
        w  = 16'd0;
        f  = fi;
        wr = 1'b1;
        case (cmd)
            CMD_ADD, CMD_ADC: begin
                r = sum9[7:0];
                f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
            end
            CMD_SUB, CMD_SBC: begin
                r = dif9[7:0];
                f = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
            end
            CMD_CP: begin
                wr = 1'b0;
                f  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
            end
            CMD_AND: begin
                r = a & b;
                f = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_OR: begin
                r = a | b;
                f = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_XOR: begin
                r = a ^ b;
                f = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC: begin
                r = a + 8'd1;
                f = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: fi.c};
            end
            CMD_DEC: begin
                r = a - 8'd1;
                f = '{z: (a == 8'd1), n: 1'b1, h: (a[3:0] == 4'd0), c: fi.c};
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR,
            CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL: begin
                r = rot_r;
                f = '{z: (rot_r == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
            end
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
                r = rot_r;
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
            end
            CMD_BIT: begin
                wr = 1'b0;
                f  = '{z: ((a & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: fi.c};
            end
            CMD_RES: begin
                r = a & ~bit_mask;
            end
            CMD_SET: begin
                r = a | bit_mask;
            end
            CMD_DAA: begin
                r = daa_r;
                f = '{z: (daa_r == 8'd0), n: fi.n, h: 1'b0, c: daa_c};
            end
            CMD_CPL: begin
                r = ~a;
                f = '{z: fi.z, n: 1'b1, h: 1'b1, c: fi.c};
            end
            CMD_CCF: begin
                wr = 1'b0;
                f  = '{z: fi.z, n: 1'b0, h: 1'b0, c: ~fi.c};
            end
            CMD_SCF: begin
                wr = 1'b0;
                f  = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            CMD_ADD16: begin
                w = w17[15:0];
                r = w17[7:0];
                f = '{z: fi.z, n: 1'b0, h: h13[12], c: w17[16]};
            end
            CMD_ADDSP: begin
                w = sp_sum;
                r = sp_sum[7:0];
                f = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
            end
            default: begin
                // unused code: pass through, nothing written
                wr = 1'b0;
            end
        endcase
    end

    assign o_rsp.result      = r;
    assign o_rsp.word_result = w;
    assign o_rsp.flags_out   = f;
    assign o_rsp.write_back  = wr;

endmodule

`default_nettype wire

// ===== rtl/core/sm83_alu_with_flags.sv =====
// sm83_alu_with_flags: top level, input register, datapath and result register
// depends on sm83alu_pkg, sm83alu_req_if, sm83alu_rsp_if and sm83alu_calc
//
//   channel  | dir | payload                                              | handshake
//   ---------+-----+------------------------------------------------------+----------
//   i_in     | in  | command acc operand bit_index flags_in word_a word_b | valid/ready
//   o_out    | out | result word_result flags_out write_back              | valid/ready
//
// one beat per cycle sustained while o_out takes each result; a beat passes the input register then the result register
// the datapath between them is a single pass of the 8-bit and 16-bit adders and muxes
// i_rst_n (synchronous, active low) empties both register stages and holds i_in.ready low
// a stall on o_out holds the result register and backs up into the input register;
// i_in.ready drops only when both stages are full and the result is not taken
`default_nettype none

module sm83_alu_with_flags (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    sm83alu_req_if.sink         i_in,
    sm83alu_rsp_if.source       o_out
);
    import sm83alu_pkg::*;

    logic     r_in_valid;
    logic     n_in_valid;
    t_alu_req r_in_data;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_rsp r_out_data;
    t_alu_rsp calc_rsp;
    logic     out_ready;
    logic     in_ready;

    // stage readiness, chained from the output side
    assign out_ready  = !r_out_valid || o_out.ready;
    assign in_ready   = !r_in_valid || out_ready;
    assign i_in.ready = in_ready && i_rst_n;

    // valid bits of both stages
    always_comb begin
        n_in_valid  = in_ready ? i_in.valid : r_in_valid;
        n_out_valid = out_ready ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_data <= i_in.data;
        end
    end

    // datapath
    sm83alu_calc u_calc (
        .i_req (r_in_data),
        .o_rsp (calc_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_data <= calc_rsp;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // a beat in the input register moves on whenever the result stage can take it
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> r_out_valid)
        else $error("input stage beat did not reach the result stage");

    // a stalled beat in the input register keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> (r_in_valid && $stable(r_in_data)))
        else $error("stalled input stage beat lost or changed");

    // no new beat taken while both stages are full and the result is stalled
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline full and stalled");

endmodule

`default_nettype wire
